### hdl/lcd_line_mode_timer_defines.svh
// Assertion macros used by the LCD line and mode timer RTL.
`ifndef LCD_LINE_MODE_TIMER_DEFINES_SVH
`define LCD_LINE_MODE_TIMER_DEFINES_SVH
`ifndef SYNTHESIS
// Checked only while out of reset.
`define LLMT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked at every clock edge, during reset too.
`define LLMT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define LLMT_ASSERT(label, prop, msg)
`define LLMT_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

### hdl/lcd_lmt_pkg.sv
// Types, timing constants and codes of the LCD line and mode timer.
`default_nettype none
package lcd_lmt_pkg;

  localparam int unsigned TimerW = 10;

  // Line timer thresholds in machine cycles.
  localparam logic [TimerW-1:0] T_OAM_END  = 10'h050;
  localparam logic [TimerW-1:0] T_XFER_END = 10'h0FC;
  localparam logic [TimerW-1:0] T_LINE_END = 10'h1C8;

  localparam logic [7:0] VBLANK_LINE = 8'd144;
  localparam logic [7:0] LAST_LINE   = 8'd153;

  // Mode codes.
  localparam logic [1:0] MODE_OAM    = 2'd0;
  localparam logic [1:0] MODE_XFER   = 2'd1;
  localparam logic [1:0] MODE_HBLANK = 2'd2;

  // Configuration register indexes.
  localparam logic [7:0] CFG_IDX_LINE_COMPARE = 8'd0;
  localparam logic [7:0] CFG_IDX_STATUS_EN    = 8'd1;

  // Status interrupt enable bits.
  localparam int unsigned EN_HBLANK  = 0;
  localparam int unsigned EN_VBLANK  = 1;
  localparam int unsigned EN_OAM     = 2;
  localparam int unsigned EN_COMPARE = 3;

  typedef struct packed {
    logic [8:0] timer;
    logic [1:0] mode;
    logic [7:0] line;
    logic       match;
    logic       prev_status;
  } state_t;

  // First member sits in the highest bits, so mode lands in bit 0 upward.
  typedef struct packed {
    logic [1:0] irq_request;
    logic [7:0] render_row;
    logic       render_request;
    logic       line_match;
    logic [7:0] line_count;
    logic [1:0] mode;
  } result_t;

  typedef struct packed {
    logic [7:0] line_compare;
    logic [3:0] status_en;
  } cfg_t;

endpackage
`default_nettype wire

### hdl/lcd_lmt_step.sv
// Next-state and result logic for one tick of the LCD line and mode timer.
`default_nettype none
module lcd_lmt_step (
  input  lcd_lmt_pkg::state_t  state_i,
  input  lcd_lmt_pkg::cfg_t    cfg_i,
  input  logic [7:0]           elapsed_i,
  output lcd_lmt_pkg::state_t  state_o,
  output lcd_lmt_pkg::result_t result_o
);
  import lcd_lmt_pkg::*;

  logic [TimerW-1:0] sum;
  logic [TimerW-1:0] wrapped;
  logic              mode_ok;
  logic              reach_xfer;
  logic              reach_hblank;
  logic              line_end;
  logic [7:0]        line_next;
  logic              match_next;
  logic              status;
  logic [1:0]        mode_next;

  assign sum     = {1'b0, state_i.timer} + {2'b0, elapsed_i};
  assign wrapped = sum - T_LINE_END;

  always_comb begin
    mode_ok      = 1'b1;
    reach_xfer   = 1'b0;
    reach_hblank = 1'b0;
    unique case (state_i.mode)
      MODE_OAM: begin
        reach_xfer   = (sum >= T_OAM_END);
        reach_hblank = reach_xfer && (sum >= T_XFER_END);
      end
      MODE_XFER: begin
        reach_xfer   = 1'b1;
        reach_hblank = (sum >= T_XFER_END);
      end
      MODE_HBLANK: begin
        reach_hblank = 1'b1;
      end
      default: begin
        mode_ok = 1'b0;
      end
    endcase
  end

  assign line_end   = reach_hblank && (sum >= T_LINE_END);
  assign line_next  = (state_i.line == LAST_LINE) ? 8'd0 : state_i.line + 8'd1;
  assign match_next = (line_next == cfg_i.line_compare);

  always_comb begin
    // After a line end, the wrapped timer picks OAM, XFER or HBLANK mode.
    mode_next = MODE_OAM;
    status    = 1'b0;
    if (mode_ok) begin
      if (reach_xfer && reach_hblank && state_i.mode != MODE_HBLANK) begin
        status = cfg_i.status_en[EN_HBLANK];
      end else if (state_i.mode == MODE_XFER && reach_hblank) begin
        status = cfg_i.status_en[EN_HBLANK];
      end
      if (!line_end) begin
        if (reach_hblank)    mode_next = MODE_HBLANK;
        else if (reach_xfer) mode_next = MODE_XFER;
        else                 mode_next = MODE_OAM;
      end else begin
        if (state_i.line == VBLANK_LINE && cfg_i.status_en[EN_VBLANK]) status = 1'b1;
        if (match_next && cfg_i.status_en[EN_COMPARE]) status = 1'b1;
        if (cfg_i.status_en[EN_OAM]) status = 1'b1;
        if (wrapped >= T_XFER_END) begin
          mode_next = MODE_HBLANK;
          if (cfg_i.status_en[EN_HBLANK]) status = 1'b1;
        end else if (wrapped >= T_OAM_END) begin
          mode_next = MODE_XFER;
        end
      end
    end
  end

  always_comb begin
    state_o             = state_i;
    state_o.timer       = line_end ? wrapped[8:0] : sum[8:0];
    state_o.mode        = mode_next;
    state_o.prev_status = status;
    if (line_end) begin
      state_o.line  = line_next;
      state_o.match = match_next;
    end
    result_o                = '0;
    result_o.mode           = mode_next;
    result_o.line_count     = state_o.line;
    result_o.line_match     = state_o.match;
    result_o.render_request = line_end && (state_i.line < VBLANK_LINE);
    result_o.render_row     = result_o.render_request ? state_i.line : 8'd0;
    result_o.irq_request[0] = line_end && (state_i.line == VBLANK_LINE);
    result_o.irq_request[1] = status && !state_i.prev_status;
  end

endmodule
`default_nettype wire

### hdl/lcd_line_mode_timer.sv
// A result passes through the input register and then the result register before it is offered.
// Throughput: one tick per clock while the result channel is not stalled; the step logic is combinational.
// The input register accepts a new tick while a finished result still waits downstream only if it is empty.
// Reset (rst_ni low, asynchronous): timer, line count, mode, flags, valid bits and configuration go to zero.
// Configuration writes are taken in every cycle and land in the next one.
`default_nettype none
`include "lcd_line_mode_timer_defines.svh"
module lcd_line_mode_timer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input ticks. tdata: [7:0] elapsed_cycles.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,
  // Results. tdata: [1:0] mode, [9:2] line_count, [10] line_match,
  // [11] render_request, [19:12] render_row, [21:20] irq_request, [23:22] zero.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,
  // Configuration writes: index 0 line_compare, index 1 status_irq_enables.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);
  import lcd_lmt_pkg::*;

  // Input stage: one tick waits here until the step logic can take it.
  logic       in_valid_q;
  logic [7:0] in_data_q;

  // Timer state, updated once per processed tick.
  state_t     state_q;
  state_t     state_d;
  result_t    result_d;

  // Result register feeding the output channel.
  logic       out_valid_q;
  result_t    out_data_q;

  cfg_t       cfg_q;
  logic       fire;

  // A tick is processed when the input stage holds one and the result register
  // is empty or being drained in this same cycle.
  assign fire            = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || fire;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00, out_data_q};
  assign cfg_ready_o     = 1'b1;

  lcd_lmt_step u_step (
    .state_i  (state_q),
    .cfg_i    (cfg_q),
    .elapsed_i(in_data_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (s_axis_tready_o) in_valid_q <= s_axis_tvalid_i;
      if (fire) begin
        state_q     <= state_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) in_data_q <= s_axis_tdata_i;
    if (fire) out_data_q <= result_d;
  end

  // Writes to an index beyond the register list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_IDX_LINE_COMPARE: cfg_q.line_compare <= cfg_data_i;
        CFG_IDX_STATUS_EN:    cfg_q.status_en    <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  `LLMT_ASSERT(a_timer_in_line, (state_q.timer < 9'd456), "line timer past line end")
  `LLMT_ASSERT(a_mode_valid, (state_q.mode <= MODE_HBLANK), "mode register holds unused code")
  `LLMT_ASSERT(a_line_in_frame, (state_q.line <= LAST_LINE), "line count beyond frame")
  `LLMT_ASSERT(a_vblank_line, (out_valid_q && out_data_q.irq_request[0] |-> out_data_q.line_count == 8'd145), "vblank irq off line")
  `LLMT_ASSERT(a_render_row, (out_valid_q && out_data_q.render_request |-> out_data_q.render_row < VBLANK_LINE), "render row not visible")
  `LLMT_ASSERT_ALWAYS(a_stall_holds, (!s_axis_tready_o |-> in_valid_q), "input stalled while empty")

endmodule
`default_nettype wire
